@@ rtl/cts_pkg.sv @@
// Package: fixed-point types, ALU opcodes, sequencer states and saturation.
package cts_pkg;

  localparam int ROWS      = 8;
  localparam int FRAC_BITS = 16;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int CNT_W     = $clog2(ROWS + 1);
  localparam int DVD_W     = 32 + FRAC_BITS;
  localparam int STEP_W    = $clog2(DVD_W + 1);

  localparam logic [31:0] FX_ONE = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] FX_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] FX_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_NEG,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic [2:0] {
    S_LOAD,
    S_FWD,
    S_BACK,
    S_CORR,
    S_FIX,
    S_OUT
  } seq_state_e;

  typedef enum logic [2:0] {
    D_T,
    D_DEN,
    D_FACT,
    D_BETA,
    D_Z,
    D_Q
  } dst_e;

  typedef struct packed {
    alu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } fx_res_t;

  function automatic fx_res_t fx_sat(input logic signed [63:0] v);
    fx_res_t r;
    if (v > $signed({32'd0, FX_MAX})) begin
      r.ovf = 1'b1;
      r.val = FX_MAX;
    end else if (v < $signed({32'hFFFF_FFFF, FX_MIN})) begin
      r.ovf = 1'b1;
      r.val = FX_MIN;
    end else begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/cts_alu.sv @@
// Shared fixed-point ALU: saturating add, sub, negate, multiply and bit-serial divide.
module cts_alu
  import cts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     go_i,
  input  alu_req_t req_i,
  output logic     done_o,
  output fx_res_t  res_o
);

  logic                     busy_q;
  alu_op_e                  op_q;
  logic signed [31:0]       a_q, b_q;
  logic signed [63:0]       prod_q;
  logic [DVD_W-1:0]         quo_q, quo_d;
  logic [31:0]              rem_q, rem_d;
  logic [31:0]              bmag_q;
  logic                     neg_q;
  logic [STEP_W-1:0]        cnt_q;
  logic [31:0]              amag;
  logic [31:0]              bmag;
  logic [32:0]              rem_sh;
  logic                     bzero;
  logic signed [63:0]       wide;

  assign amag  = req_i.a[31] ? (~req_i.a + 32'd1) : req_i.a;
  assign bmag  = req_i.b[31] ? (~req_i.b + 32'd1) : req_i.b;
  assign bzero = (b_q == 32'sd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      cnt_q  <= STEP_W'(DVD_W);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_comb begin
    rem_sh = {rem_q, quo_q[DVD_W-1]};
    if (rem_sh >= {1'b0, bmag_q}) begin
      rem_d = rem_sh[31:0] - bmag_q;
      quo_d = {quo_q[DVD_W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[31:0];
      quo_d = {quo_q[DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      op_q   <= req_i.op;
      a_q    <= req_i.a;
      b_q    <= req_i.b;
      prod_q <= $signed(req_i.a) * $signed(req_i.b);
      quo_q  <= {amag, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      bmag_q <= bmag;
      neg_q  <= req_i.a[31] ^ req_i.b[31];
    end else if (busy_q && op_q == ALU_DIV) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = busy_q && (op_q != ALU_DIV || bzero || cnt_q == '0);

  always_comb begin
    wide = '0;
    unique case (op_q)
      ALU_ADD: wide = 64'(a_q) + 64'(b_q);
      ALU_SUB: wide = 64'(a_q) - 64'(b_q);
      ALU_NEG: wide = -64'(a_q);
      ALU_MUL: wide = prod_q >>> FRAC_BITS;
      ALU_DIV: wide = neg_q ? -$signed({{(64-DVD_W){1'b0}}, quo_q})
                            :  $signed({{(64-DVD_W){1'b0}}, quo_q});
      default: wide = '0;
    endcase
    res_o = fx_sat(wide);
    if (op_q == ALU_DIV && bzero) begin
      res_o.ovf = 1'b1;
      res_o.val = a_q[31] ? FX_MIN : FX_MAX;
    end
  end

endmodule

@@ rtl/cyclic_tridiagonal_solver_core.sv @@
// Top level: row stores and solve sequencer around one shared fixed-point ALU.
// A row loads on each accepted start_i; busy_o stays high from the last row to the last result.
// The solve uses the serial divide three times per row in the forward sweep and twice on
// the last row, alongside the add, sub and multiply steps; a zero divisor ends a divide early.
// A full system holds eight rows; results follow back to back with sol_valid_o,
// last_out_o marking the last one, and the receiver cannot stall.
// Reset clears the sequencer, row count and error flag; the stores are not cleared.
module cyclic_tridiagonal_solver_core
  import cts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] diag_value_i,
  input  logic [31:0] off_value_i,
  input  logic [31:0] rhs_value_i,
  input  logic        last_row_i,
  output logic        sol_valid_o,
  output logic [31:0] solution_o,
  output logic        last_out_o,
  output logic        error_o
);

  logic [31:0] diag_q [ROWS];
  logic [31:0] off_q  [ROWS];
  logic [31:0] rhs_q  [ROWS];
  logic [31:0] beta_q [ROWS];
  logic [31:0] z_q    [ROWS];
  logic [31:0] q_q    [ROWS];

  seq_state_e       state_q, state_d;
  logic [3:0]       sub_q, sub_d;
  logic [ROW_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             err_q, err_d;
  logic             wait_q, wait_d;
  logic [31:0]      t_q, den_q, fact_q;

  alu_req_t         req;
  fx_res_t          alu_res;
  logic             alu_done;
  logic             go;
  logic             skip;
  logic             wr;
  logic             adv;
  dst_e             dst;
  logic [ROW_W-1:0] idx;
  logic [ROW_W-1:0] im1;
  logic [ROW_W-1:0] nm1;
  logic [CNT_W-1:0] nm1_w;
  logic             i0;
  logic             is_last;
  logic             full;
  logic             accept;

  assign im1     = i_q - 1'b1;
  assign nm1_w   = cnt_q - 1'b1;
  assign nm1     = nm1_w[ROW_W-1:0];
  assign i0      = (i_q == '0);
  assign is_last = (i_q == nm1);
  assign full    = (cnt_q == CNT_W'(ROWS));
  assign busy_o  = (state_q != S_LOAD);
  assign accept  = start_i && !busy_o;

  cts_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .req_i  (req),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  always_comb begin
    req  = '{op: ALU_ADD, a: '0, b: '0};
    dst  = D_T;
    idx  = i_q;
    skip = 1'b0;
    unique case (state_q)
      S_FWD: begin
        case (sub_q)
          4'd0: begin
            req = '{op: ALU_MUL, a: i0 ? '0 : off_q[i_q], b: i0 ? '0 : beta_q[im1]};
          end
          4'd1: begin
            req = '{op: ALU_ADD, a: t_q, b: diag_q[i_q]};
            dst = D_DEN;
          end
          4'd2: begin
            req  = '{op: ALU_NEG, a: off_q[i_q], b: '0};
            skip = is_last;
          end
          4'd3: begin
            req  = '{op: ALU_DIV, a: t_q, b: den_q};
            dst  = D_BETA;
            skip = is_last;
          end
          4'd4: begin
            req = '{op: ALU_MUL, a: i0 ? '0 : off_q[i_q], b: i0 ? '0 : z_q[im1]};
          end
          4'd5: begin
            req = '{op: ALU_SUB, a: rhs_q[i_q], b: t_q};
          end
          4'd6: begin
            req = '{op: ALU_DIV, a: t_q, b: den_q};
            dst = D_Z;
          end
          4'd7: begin
            req = '{op: ALU_MUL, a: i0 ? '0 : off_q[i_q], b: i0 ? '0 : q_q[im1]};
          end
          4'd8: begin
            req = '{op: ALU_SUB, a: (i0 || is_last) ? FX_ONE : '0, b: t_q};
          end
          default: begin
            req = '{op: ALU_DIV, a: t_q, b: den_q};
            dst = D_Q;
          end
        endcase
      end
      S_BACK: begin
        case (sub_q)
          4'd0: req = '{op: ALU_MUL, a: beta_q[im1], b: z_q[i_q]};
          4'd1: begin
            req = '{op: ALU_ADD, a: t_q, b: z_q[im1]};
            dst = D_Z;
            idx = im1;
          end
          4'd2: req = '{op: ALU_MUL, a: beta_q[im1], b: q_q[i_q]};
          default: begin
            req = '{op: ALU_ADD, a: t_q, b: q_q[im1]};
            dst = D_Q;
            idx = im1;
          end
        endcase
      end
      S_CORR: begin
        case (sub_q)
          4'd0: begin
            req = '{op: ALU_ADD, a: z_q[0], b: z_q[nm1]};
            dst = D_FACT;
          end
          4'd1: req = '{op: ALU_ADD, a: q_q[0], b: q_q[nm1]};
          4'd2: begin
            req = '{op: ALU_ADD, a: t_q, b: FX_ONE};
            dst = D_DEN;
          end
          default: begin
            req = '{op: ALU_DIV, a: fact_q, b: den_q};
            dst = D_FACT;
          end
        endcase
      end
      S_FIX: begin
        if (sub_q == 4'd0) begin
          req = '{op: ALU_MUL, a: fact_q, b: q_q[i_q]};
        end else begin
          req = '{op: ALU_SUB, a: z_q[i_q], b: t_q};
          dst = D_Z;
        end
      end
      default: begin
        skip = 1'b0;
      end
    endcase
  end

  assign go  = (state_q == S_FWD || state_q == S_BACK || state_q == S_CORR ||
                state_q == S_FIX) && !skip && !wait_q;
  assign wr  = wait_q && alu_done;
  assign adv = wr || (skip && !wait_q);

  always_comb begin
    state_d = state_q;
    sub_d   = sub_q;
    i_d     = i_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    wait_d  = go ? 1'b1 : (wr ? 1'b0 : wait_q);
    if (wr && alu_res.ovf) begin
      err_d = 1'b1;
    end
    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (full) begin
            err_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
          if (last_row_i) begin
            state_d = S_FWD;
            sub_d   = '0;
            i_d     = '0;
          end
        end
      end
      S_FWD: begin
        if (adv) begin
          if (sub_q == 4'd9) begin
            sub_d = '0;
            if (is_last) begin
              state_d = i0 ? S_CORR : S_BACK;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            sub_d = sub_q + 1'b1;
          end
        end
      end
      S_BACK: begin
        if (adv) begin
          if (sub_q == 4'd3) begin
            sub_d = '0;
            if (i_q == ROW_W'(1)) begin
              state_d = S_CORR;
            end else begin
              i_d = im1;
            end
          end else begin
            sub_d = sub_q + 1'b1;
          end
        end
      end
      S_CORR: begin
        if (adv) begin
          if (sub_q == 4'd3) begin
            sub_d   = '0;
            i_d     = '0;
            state_d = S_FIX;
          end else begin
            sub_d = sub_q + 1'b1;
          end
        end
      end
      S_FIX: begin
        if (adv) begin
          if (sub_q == 4'd1) begin
            sub_d = '0;
            if (is_last) begin
              state_d = S_OUT;
              i_d     = '0;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            sub_d = sub_q + 1'b1;
          end
        end
      end
      S_OUT: begin
        if (is_last) begin
          state_d = S_LOAD;
          cnt_d   = '0;
          err_d   = 1'b0;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      sub_q   <= '0;
      i_q     <= '0;
      cnt_q   <= '0;
      err_q   <= 1'b0;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
      i_q     <= i_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      wait_q  <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !full) begin
      diag_q[cnt_q[ROW_W-1:0]] <= diag_value_i;
      off_q[cnt_q[ROW_W-1:0]]  <= off_value_i;
      rhs_q[cnt_q[ROW_W-1:0]]  <= rhs_value_i;
    end
    if (wr) begin
      case (dst)
        D_T:     t_q         <= alu_res.val;
        D_DEN:   den_q       <= alu_res.val;
        D_FACT:  fact_q      <= alu_res.val;
        D_BETA:  beta_q[idx] <= alu_res.val;
        D_Z:     z_q[idx]    <= alu_res.val;
        default: q_q[idx]    <= alu_res.val;
      endcase
    end
  end

  assign sol_valid_o = (state_q == S_OUT);
  assign solution_o  = z_q[i_q];
  assign last_out_o  = is_last;
  assign error_o     = err_q;

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sol_valid_o |-> busy_o) else $error("result strobe while idle");

  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> wait_q) else $error("ALU done without pending op");

  a_no_double_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> !go) else $error("ALU issued twice in a row");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sol_valid_o && last_out_o) |=> !busy_o) else $error("not idle after last result");

endmodule
